### src/npcs_pkg.sv
// shared types and constants for the nearest palette color search block
package npcs_pkg;

    localparam int DEFAULT_DEPTH = 256;

    localparam int SIZE_W  = 9;
    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int DIST_W  = 18;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int WORD_W  = 4 * CHAN_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET     = 9'd256;
    localparam logic [DIST_W-1:0] START_DISTANCE = 18'd195076;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LK_RD,
        ST_LK_DATA
    } state_t;

endpackage

### src/nearest_palette_color_search.sv
// nearest palette color search: palette memory, distance unit and sequencer
//
// s_ channel carries one item: tuser holds the mode, tdata the entry index and
// an RGBA color. mode 0 writes one palette entry and gives no result. mode 1
// searches the first palette_size entries for the nearest color by squared
// RGB distance, lowest index on ties. mode 2 reads one entry back.
// m_ channel returns one item for modes 1 and 2, with the status in tuser.
// cfg_ channel writes palette_size; it is taken at any time, ready is tied high.
// a load writes its entry when it is taken. a lookup goes through the read
// and data states to the result register; an empty palette or an out of range
// index loads the result register as the item is taken. a search reads one
// entry per cycle from the single read port of the palette memory through a 3
// stage read, distance and compare pipe, palette_size capped at PALETTE_DEPTH.
// the block holds s_tready low while an item is at work and while a result
// waits in the output register, so a stalled receiver stalls the input.
// reset sets palette_size to 256 and clears the per-entry written flags, so
// every entry reads as its gray ramp value i,i,i with alpha zero at once.
module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = npcs_pkg::DEFAULT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, red, green, blue, alpha
    input  logic [npcs_pkg::S_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [npcs_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_index, min_distance, out_red, out_green, out_blue, out_alpha
    output logic [npcs_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [npcs_pkg::STAT_W-1:0]    m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npcs_pkg::SIZE_W-1:0]    cfg_data
);

    import npcs_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);

    logic [WORD_W-1:0]    mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] written_reg;

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    n_use;
    logic [SIZE_W-1:0]    cnt_reg, cnt_next;
    logic [CHAN_W-1:0]    pix_r_reg, pix_g_reg, pix_b_reg;
    logic [CHAN_W-1:0]    pix_r_next, pix_g_next, pix_b_next;

    logic [WORD_W-1:0]    rd_word_reg;
    logic                 rd_written_reg;
    logic [AW-1:0]        rd_tag_reg;
    logic                 rd_vld_reg;
    logic [AW-1:0]        rd_addr;
    logic [WORD_W-1:0]    rd_color;

    logic [DIST_W-1:0]    dist_reg;
    logic [AW-1:0]        dist_tag_reg;
    logic                 dist_vld_reg;
    logic [DIST_W-1:0]    dist_calc;

    logic [DIST_W-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [MODE_W-1:0]    in_mode;
    logic [IDX_W-1:0]     in_idx;
    logic [CHAN_W-1:0]    in_r, in_g, in_b, in_a;
    logic                 s_fire;
    logic                 issue;
    logic                 search_done;
    logic                 wr_en;

    assign in_mode = s_tuser;
    assign in_idx  = s_tdata[7:0];
    assign in_r    = s_tdata[15:8];
    assign in_g    = s_tdata[23:16];
    assign in_b    = s_tdata[31:24];
    assign in_a    = s_tdata[39:32];

    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign n_use       = (size_reg > DEPTH_SZ) ? DEPTH_SZ : size_reg;
    assign rd_addr     = cnt_reg[AW-1:0];
    assign issue       = (state_reg == ST_SEARCH) && (cnt_reg < n_use);
    assign search_done = (state_reg == ST_SEARCH) && !issue && !rd_vld_reg && !dist_vld_reg;
    assign wr_en       = s_fire && (in_mode == MODE_LOAD)
                         && ({1'b0, in_idx} < DEPTH_SZ);

    // palette memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_idx[AW-1:0]] <= {in_a, in_b, in_g, in_r};
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[in_idx[AW-1:0]] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    // unwritten entries read as the gray ramp
    assign rd_color = rd_written_reg ? rd_word_reg
                    : {CHAN_W'(0), CHAN_W'(rd_tag_reg), CHAN_W'(rd_tag_reg),
                       CHAN_W'(rd_tag_reg)};

    // distance unit
    always_comb begin
        logic [CHAN_W-1:0] dr, dg, db;
        logic [2*CHAN_W-1:0] sr, sg, sb;
        dr = (rd_color[7:0] > pix_r_reg) ? rd_color[7:0] - pix_r_reg
                                          : pix_r_reg - rd_color[7:0];
        dg = (rd_color[15:8] > pix_g_reg) ? rd_color[15:8] - pix_g_reg
                                           : pix_g_reg - rd_color[15:8];
        db = (rd_color[23:16] > pix_b_reg) ? rd_color[23:16] - pix_b_reg
                                            : pix_b_reg - rd_color[23:16];
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        dist_calc = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && n_use != '0) begin
                    if (in_mode == MODE_SEARCH) begin
                        state_next = ST_SEARCH;
                    end else if (in_mode == MODE_LOOKUP && {1'b0, in_idx} < n_use) begin
                        state_next = ST_LK_RD;
                    end
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LK_RD:   state_next = ST_LK_DATA;
            ST_LK_DATA: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        cnt_next      = cnt_reg;
        pix_r_next    = pix_r_reg;
        pix_g_next    = pix_g_reg;
        pix_b_next    = pix_b_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pix_r_next    = in_r;
                    pix_g_next    = in_g;
                    pix_b_next    = in_b;
                    best_next     = START_DISTANCE;
                    best_idx_next = '0;
                    cnt_next      = (in_mode == MODE_LOOKUP) ? {1'b0, in_idx} : '0;
                    if (in_mode == MODE_SEARCH || in_mode == MODE_LOOKUP) begin
                        if (n_use == '0) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = '0;
                            m_tuser_next  = STAT_EMPTY;
                        end else if (in_mode == MODE_LOOKUP && {1'b0, in_idx} >= n_use) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = '0;
                            m_tuser_next  = STAT_RANGE;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (issue) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (dist_vld_reg && dist_reg < best_reg) begin
                    best_next     = dist_reg;
                    best_idx_next = IDX_W'(dist_tag_reg);
                end
                if (search_done) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({best_reg, best_idx_reg});
                    m_tuser_next  = STAT_OK;
                end
            end
            ST_LK_RD: begin
            end
            ST_LK_DATA: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {6'b0, rd_color, 18'b0, 8'b0};
                m_tuser_next  = STAT_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            dist_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= issue;
            dist_vld_reg <= rd_vld_reg;
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        pix_r_reg    <= pix_r_next;
        pix_g_reg    <= pix_g_next;
        pix_b_reg    <= pix_b_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        rd_tag_reg   <= rd_addr;
        dist_reg     <= dist_calc;
        dist_tag_reg <= rd_tag_reg;
    end

endmodule
